// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the single-wire bit transmitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== hdl/swbt_pkg.sv =====
// Types and constants of the single-wire bit transmitter.
package swbt_pkg;

	localparam int MODE_W = 2;
	localparam int DATA_W = 8;
	localparam int TICKS_W = 4;

	// Command codes carried by the mode field.
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd2;

	localparam logic [TICKS_W-1:0] RESET_TICKS_DEFAULT = 4'd5;

	// Three ticks per bit: pull low, sample, release.
	typedef enum logic [1:0] {
		PH_DRIVE   = 2'd0,
		PH_SAMPLE  = 2'd1,
		PH_RELEASE = 2'd2
	} phase_t;

endpackage

// ===== hdl/single_wire_bit_transmitter.sv =====
// Single-wire bit transmitter: reset pulse, byte send with collision check.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | input     | in_valid / in_ready  | mode, line_low, tx_byte
//  out     | output    | out_valid / out_ready| drive_low, reset_done, byte_done,
//          |           |                      | collision, wire_byte
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (reset_ticks)
//
// Every accepted transaction yields one result, registered and held in the
// output register; a new transaction is taken each cycle while that register
// is empty or being drained. The bit and reset state advances in the same
// cycle the transaction is accepted. A stalled output holds the input off.
// Reset releases the line, clears the bit and reset state and the output valid flag, and sets reset_ticks to 5.
// The configuration write is always ready and takes effect on the next cycle.
`include "assert_macros.svh"

module single_wire_bit_transmitter #(
	parameter int BYTE_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [swbt_pkg::MODE_W-1:0]       mode,
	input  logic                              line_low,
	input  logic [swbt_pkg::DATA_W-1:0]       tx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              drive_low,
	output logic                              reset_done,
	output logic                              byte_done,
	output logic                              collision,
	output logic [swbt_pkg::DATA_W-1:0]       wire_byte,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swbt_pkg::TICKS_W-1:0]      cfg_data
);

	localparam int CNT_W = $clog2(BYTE_BITS + 1);
	localparam logic [CNT_W-1:0] BITS_FULL = CNT_W'(BYTE_BITS);
	localparam int DW = swbt_pkg::DATA_W;

	swbt_pkg::phase_t                phase_q, phase_d;
	logic                            sending_q, sending_d;
	logic                            want_one_q, want_one_d;
	logic                            collided_q, collided_d;
	logic [DW-1:0]                   shifter_q, shifter_d;
	logic [CNT_W-1:0]                bits_left_q, bits_left_d;
	logic                            line_driven_q, line_driven_d;
	logic                            reset_active_q, reset_active_d;
	logic [swbt_pkg::TICKS_W-1:0]    reset_count_q, reset_count_d;
	logic [swbt_pkg::TICKS_W-1:0]    reset_ticks_q;
	logic                            done_d;
	logic                            reset_done_d;
	logic [DW-1:0]                   shift_or;
	logic [CNT_W-1:0]                bits_dec;

	logic                            out_valid_q;
	logic                            drive_low_q;
	logic                            reset_done_q;
	logic                            byte_done_q;
	logic                            collision_q;
	logic [DW-1:0]                   wire_byte_q;

	logic                            in_take;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_take   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign shift_or = shifter_q | {{(DW-1){1'b0}}, want_one_q};
	assign bits_dec = bits_left_q - {{(CNT_W-1){1'b0}}, 1'b1};

	// Next state for one transaction.
	always_comb begin
		phase_d        = phase_q;
		sending_d      = sending_q;
		want_one_d     = want_one_q;
		collided_d     = collided_q;
		shifter_d      = shifter_q;
		bits_left_d    = bits_left_q;
		line_driven_d  = line_driven_q;
		reset_active_d = reset_active_q;
		reset_count_d  = reset_count_q;
		done_d         = 1'b0;
		case (mode)
			swbt_pkg::MODE_START: begin
				sending_d      = 1'b0;
				want_one_d     = 1'b0;
				phase_d        = swbt_pkg::PH_DRIVE;
				collided_d     = 1'b0;
				line_driven_d  = 1'b1;
				reset_active_d = 1'b1;
				reset_count_d  = '0;
			end
			swbt_pkg::MODE_LOAD: begin
				reset_active_d = 1'b0;
				reset_count_d  = '0;
				line_driven_d  = 1'b0;
				shifter_d      = tx_byte;
				bits_left_d    = BITS_FULL;
				sending_d      = 1'b1;
				phase_d        = swbt_pkg::PH_DRIVE;
				want_one_d     = tx_byte[DW-1];
			end
			swbt_pkg::MODE_TICK: begin
				if (sending_q) begin
					case (phase_q)
						swbt_pkg::PH_DRIVE: begin
							line_driven_d = 1'b1;
							phase_d       = swbt_pkg::PH_SAMPLE;
						end
						swbt_pkg::PH_SAMPLE: begin
							if (!want_one_q)
								line_driven_d = 1'b0;
							want_one_d = want_one_q | line_low;
							phase_d    = swbt_pkg::PH_RELEASE;
						end
						default: begin
							line_driven_d = 1'b0;
							phase_d       = swbt_pkg::PH_DRIVE;
							// The wire went low while this node sent a zero.
							if (!shifter_q[DW-1] && want_one_q) begin
								collided_d = 1'b1;
								sending_d  = 1'b0;
								want_one_d = 1'b0;
							end else begin
								bits_left_d = bits_dec;
								if (bits_dec == '0) begin
									shifter_d  = shift_or;
									want_one_d = 1'b0;
									sending_d  = 1'b0;
									done_d     = 1'b1;
								end else begin
									shifter_d  = {shift_or[DW-2:0], 1'b0};
									want_one_d = shift_or[DW-2];
								end
							end
						end
					endcase
				end else if (reset_active_q && (reset_count_q < reset_ticks_q)) begin
					reset_count_d = reset_count_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields derived from the next state.
	always_comb begin
		reset_done_d = reset_active_d && (reset_count_d >= reset_ticks_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= swbt_pkg::PH_DRIVE;
			sending_q      <= 1'b0;
			want_one_q     <= 1'b0;
			collided_q     <= 1'b0;
			shifter_q      <= '0;
			bits_left_q    <= '0;
			line_driven_q  <= 1'b0;
			reset_active_q <= 1'b0;
			reset_count_q  <= '0;
		end else if (in_take) begin
			phase_q        <= phase_d;
			sending_q      <= sending_d;
			want_one_q     <= want_one_d;
			collided_q     <= collided_d;
			shifter_q      <= shifter_d;
			bits_left_q    <= bits_left_d;
			line_driven_q  <= line_driven_d;
			reset_active_q <= reset_active_d;
			reset_count_q  <= reset_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_ticks_q <= swbt_pkg::RESET_TICKS_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			reset_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			drive_low_q  <= line_driven_d;
			reset_done_q <= reset_done_d;
			byte_done_q  <= done_d;
			collision_q  <= collided_d;
			wire_byte_q  <= shifter_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign drive_low  = drive_low_q;
	assign reset_done = reset_done_q;
	assign byte_done  = byte_done_q;
	assign collision  = collision_q;
	assign wire_byte  = wire_byte_q;

	`ASSERT_NEVER(a_reset_and_send, clk, arst_n, reset_active_q && sending_q, "reset pulse and send both active")
	`ASSERT_PROP(a_done_releases, clk, arst_n, (out_valid && byte_done) |-> !drive_low, "byte done with line driven")
	`ASSERT_PROP(a_load_starts, clk, arst_n, (in_take && (mode == swbt_pkg::MODE_LOAD)) |=> (sending_q && (bits_left_q == BITS_FULL)), "load did not start a send")

endmodule

// ===== sim/single_wire_bit_transmitter_checker.sv =====
`timescale 1ns / 100ps
// Checker for the single-wire bit transmitter: predicts every result and compares it.
module single_wire_bit_transmitter_checker #(
	parameter int BYTE_BITS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic [swbt_pkg::MODE_W-1:0]            mode,
	input  logic                                   line_low,
	input  logic [swbt_pkg::DATA_W-1:0]            tx_byte,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic                                   drive_low,
	input  logic                                   reset_done,
	input  logic                                   byte_done,
	input  logic                                   collision,
	input  logic [swbt_pkg::DATA_W-1:0]            wire_byte,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [swbt_pkg::TICKS_W-1:0]           cfg_data,
	output int                                     mismatch_count,
	output int                                     results_pending
);

	typedef struct packed {
		logic                        drive_low;
		logic                        reset_done;
		logic                        byte_done;
		logic                        collision;
		logic [swbt_pkg::DATA_W-1:0] wire_byte;
	} line_out_t;

	swbt_pkg::phase_t               bit_phase;
	logic                           sending;
	logic                           want_one;
	logic                           collided;
	logic                           line_driven;
	logic                           pulse_active;
	logic [swbt_pkg::DATA_W-1:0]    shifter;
	logic [4:0]                     bits_left;
	logic [swbt_pkg::TICKS_W-1:0]   pulse_count;
	logic [swbt_pkg::TICKS_W-1:0]   pulse_ticks;
	line_out_t                      awaited_outputs[$];

	task automatic advance_transmitter(input logic [swbt_pkg::MODE_W-1:0] m, input logic low,
			input logic [swbt_pkg::DATA_W-1:0] data, output line_out_t r);
		logic done;
		done = 1'b0;
		if (m == swbt_pkg::MODE_START) begin
			sending = 1'b0;
			want_one = 1'b0;
			bit_phase = swbt_pkg::PH_DRIVE;
			collided = 1'b0;
			line_driven = 1'b1;
			pulse_active = 1'b1;
			pulse_count = '0;
		end else if (m == swbt_pkg::MODE_LOAD) begin
			pulse_active = 1'b0;
			pulse_count = '0;
			line_driven = 1'b0;
			shifter = data;
			bits_left = 5'(BYTE_BITS);
			sending = 1'b1;
			bit_phase = swbt_pkg::PH_DRIVE;
			want_one = data[swbt_pkg::DATA_W-1];
		end else if (m == swbt_pkg::MODE_TICK && sending) begin
			case (bit_phase)
				swbt_pkg::PH_DRIVE: begin
					line_driven = 1'b1;
					bit_phase = swbt_pkg::PH_SAMPLE;
				end
				swbt_pkg::PH_SAMPLE: begin
					if (!want_one)
						line_driven = 1'b0;
					if (low)
						want_one = 1'b1;
					bit_phase = swbt_pkg::PH_RELEASE;
				end
				default: begin
					line_driven = 1'b0;
					bit_phase = swbt_pkg::PH_DRIVE;
					// A low wire while a 0 goes out means another node is sending a 1.
					if (!shifter[swbt_pkg::DATA_W-1] && want_one) begin
						collided = 1'b1;
						sending = 1'b0;
						want_one = 1'b0;
					end else begin
						shifter[0] = shifter[0] | want_one;
						want_one = 1'b0;
						bits_left = bits_left - 5'd1;
						if (bits_left == 5'd0) begin
							sending = 1'b0;
							done = 1'b1;
						end else begin
							shifter = shifter << 1;
							want_one = shifter[swbt_pkg::DATA_W-1];
						end
					end
				end
			endcase
		end else if (m == swbt_pkg::MODE_TICK && pulse_active && pulse_count < pulse_ticks) begin
			pulse_count = pulse_count + 1'b1;
		end
		r.drive_low = line_driven;
		r.reset_done = pulse_active && (pulse_count >= pulse_ticks);
		r.byte_done = done;
		r.collision = collided;
		r.wire_byte = shifter;
	endtask

	function automatic int field_mismatch(string field, int want, int got);
		if (want == got)
			return 0;
		$error("%s: expected %0d, got %0d", field, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		line_out_t want;
		if (!arst_n) begin
			bit_phase = swbt_pkg::PH_DRIVE;
			sending = 1'b0;
			want_one = 1'b0;
			collided = 1'b0;
			line_driven = 1'b0;
			pulse_active = 1'b0;
			shifter = '0;
			bits_left = '0;
			pulse_count = '0;
			pulse_ticks = swbt_pkg::RESET_TICKS_DEFAULT;
			awaited_outputs.delete();
			mismatch_count = 0;
			results_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_outputs.size() == 0) begin
					$error("result transaction with no input transaction outstanding");
					mismatch_count++;
				end else begin
					want = awaited_outputs.pop_front();
					mismatch_count += field_mismatch("drive_low",
						int'(want.drive_low), int'(drive_low));
					mismatch_count += field_mismatch("reset_done",
						int'(want.reset_done), int'(reset_done));
					mismatch_count += field_mismatch("byte_done",
						int'(want.byte_done), int'(byte_done));
					mismatch_count += field_mismatch("collision",
						int'(want.collision), int'(collision));
					mismatch_count += field_mismatch("wire_byte",
						int'(want.wire_byte), int'(wire_byte));
				end
			end
			if (in_valid && in_ready) begin
				advance_transmitter(mode, line_low, tx_byte, want);
				awaited_outputs.push_back(want);
			end
			// A new pulse length only applies from the next cycle on.
			if (cfg_valid && cfg_ready)
				pulse_ticks = cfg_data;
			results_pending = awaited_outputs.size();
		end
	end

endmodule

// ===== sim/single_wire_bit_transmitter_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the single-wire bit transmitter: stimulus, idling phases and verdict.
module single_wire_bit_transmitter_test;

	typedef logic [swbt_pkg::MODE_W-1:0] mode_t;
	typedef logic [swbt_pkg::DATA_W-1:0] data_t;

	localparam mode_t MODE_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int CYCLE_LIMIT = 200000;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [swbt_pkg::MODE_W-1:0]   mode;
	logic                          line_low;
	logic [swbt_pkg::DATA_W-1:0]   tx_byte;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          drive_low;
	logic                          reset_done;
	logic                          byte_done;
	logic                          collision;
	logic [swbt_pkg::DATA_W-1:0]   wire_byte;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [swbt_pkg::TICKS_W-1:0]  cfg_data;

	int idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;
	int sent_items = 0;
	int mismatch_count;
	int results_pending;

	single_wire_bit_transmitter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.line_low  (line_low),
		.tx_byte   (tx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive_low (drive_low),
		.reset_done(reset_done),
		.byte_done (byte_done),
		.collision (collision),
		.wire_byte (wire_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	single_wire_bit_transmitter_checker line_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.line_low       (line_low),
		.tx_byte        (tx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive_low      (drive_low),
		.reset_done     (reset_done),
		.byte_done      (byte_done),
		.collision      (collision),
		.wire_byte      (wire_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.results_pending(results_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("single_wire_bit_transmitter_test: errors");
			$finish;
		end
	end

	// Called and returning on a falling edge.
	task automatic send_item(input mode_t m, input logic low, input data_t data);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		line_low <= low;
		tx_byte <= data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		if (m != MODE_UNUSED)
			sent_items++;
	endtask

	task automatic write_reset_ticks(input logic [swbt_pkg::TICKS_W-1:0] value);
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (results_pending != 0);
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic data_t random_byte();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return data_t'($urandom);
		endcase
	endfunction

	// Loads a byte and follows it with up to three ticks per bit. The wire level
	// only matters on the sampling tick, where it mostly mirrors the bit sent.
	task automatic clock_out_frame(input data_t data, input int ticks);
		int t;
		logic low;
		send_item(swbt_pkg::MODE_LOAD, 1'($urandom_range(1)), data);
		for (t = 0; t < ticks; t++) begin
			if (t % 3 != 1)
				low = 1'($urandom_range(1));
			else if (data[swbt_pkg::DATA_W-1 - t / 3])
				low = ($urandom_range(15) != 0);
			else
				low = ($urandom_range(99) < 4);
			send_item(swbt_pkg::MODE_TICK, low, data_t'($urandom));
		end
	endtask

	task automatic send_pulse();
		int n;
		n = $urandom_range(17);
		send_item(swbt_pkg::MODE_START, 1'($urandom_range(1)), data_t'($urandom));
		repeat (n)
			send_item(swbt_pkg::MODE_TICK, 1'($urandom_range(1)), data_t'($urandom));
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 4))
			send_item(mode_t'($urandom_range(3)), 1'($urandom_range(1)), data_t'($urandom));
	endtask

	initial begin : stimulus
		int phase;
		int target;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = swbt_pkg::MODE_TICK;
		line_low = 1'b0;
		tx_byte = '0;
		cfg_valid = 1'b0;
		cfg_data = swbt_pkg::RESET_TICKS_DEFAULT;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with the pulse length still at its reset value.
		send_item(MODE_UNUSED, 1'b1, 8'hFF);
		send_item(swbt_pkg::MODE_TICK, 1'b1, 8'hFF);
		send_item(swbt_pkg::MODE_START, 1'b1, 8'hFF);
		repeat (6)
			send_item(swbt_pkg::MODE_TICK, 1'b0, 8'h00);
		send_item(swbt_pkg::MODE_LOAD, 1'b0, 8'h80);
		send_item(swbt_pkg::MODE_TICK, 1'b0, 8'h00);
		send_item(swbt_pkg::MODE_TICK, 1'b1, 8'h00);
		send_item(swbt_pkg::MODE_TICK, 1'b0, 8'h00);
		// Second bit is a 0 but the wire reads low: collision.
		send_item(swbt_pkg::MODE_TICK, 1'b0, 8'h00);
		send_item(swbt_pkg::MODE_TICK, 1'b1, 8'h00);
		send_item(swbt_pkg::MODE_TICK, 1'b0, 8'h00);
		send_item(swbt_pkg::MODE_TICK, 1'b1, 8'h00);
		// A load keeps the collision flag; only a start clears it.
		send_item(swbt_pkg::MODE_LOAD, 1'b1, 8'h00);
		repeat (3)
			send_item(swbt_pkg::MODE_TICK, 1'b0, 8'hFF);
		send_item(swbt_pkg::MODE_START, 1'b0, 8'h00);
		send_item(swbt_pkg::MODE_LOAD, 1'b0, 8'hFF);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					write_reset_ticks(4'd12);
				end
				1: begin
					idle_pct = 52;
					stall_pct = 0;
					write_reset_ticks(4'd1);
				end
				2: begin
					idle_pct = 0;
					stall_pct = 52;
					write_reset_ticks(4'd0);
				end
				default: begin
					idle_pct = 8;
					stall_pct = 8;
					write_reset_ticks(4'd15);
				end
			endcase
			target = sent_items + ITEMS_PER_PHASE;
			while (sent_items < target) begin
				pick = $urandom_range(99);
				if (pick < 55)
					clock_out_frame(random_byte(), 3 * 8);
				else if (pick < 75)
					send_pulse();
				else if (pick < 88)
					clock_out_frame(random_byte(), $urandom_range(23));
				else
					send_noise();
			end
		end

		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (results_pending != 0);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("single_wire_bit_transmitter_test: clean");
		else
			$display("single_wire_bit_transmitter_test: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/swbt_pkg.sv
hdl/single_wire_bit_transmitter.sv
sim/single_wire_bit_transmitter_checker.sv
sim/single_wire_bit_transmitter_test.sv
